/* design/sbusfd_pkg.sv */
// Shared types and constants of the SBUS frame decoder.
// No dependencies; compiled first.
`default_nettype none

package sbusfd_pkg;

  // Frame layout
  localparam logic [7:0] HDR_BYTE      = 8'h0F;
  localparam logic [7:0] FTR_BYTE      = 8'h00;
  localparam int         NUM_CH        = 10;
  localparam int         CH_BITS       = 11;
  localparam int         STORE_DEPTH   = 24;
  localparam int         POS_W         = $clog2(STORE_DEPTH);
  localparam int         BODY_LAST     = 23;
  localparam int         LOST_FLAG_BIT = 3;

  // Scaling: (raw - 1024) * 100 / 671 as |d| * SCALE_MULT >> SCALE_SHIFT,
  // exact for |d| up to 1024
  localparam int          RAW_W       = CH_BITS;
  localparam int          SCALE_SHIFT = 20;
  localparam int          MULT_W      = 18;
  localparam logic [17:0] SCALE_MULT  = 18'd156271;
  localparam int          PROD_W      = RAW_W + MULT_W;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] MS_MAX        = 16'hFFFF;

  // Request opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic signed [8:0] chan_t;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_NOSIG  = 2'd1,
    ST_NODEV  = 2'd2
  } link_status_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_FOOT = 2'd2
  } parse_phase_t;

endpackage

`default_nettype wire

/* design/sbusfd_if.sv */
// Valid/ready channel interfaces of the SBUS frame decoder.
// Depends on sbusfd_pkg for the channel value type.
`default_nettype none

interface sbusfd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sbusfd_out_if;
  logic               valid;
  logic               ready;
  sbusfd_pkg::chan_t  chan0;
  sbusfd_pkg::chan_t  chan1;
  sbusfd_pkg::chan_t  chan2;
  sbusfd_pkg::chan_t  chan3;
  sbusfd_pkg::chan_t  chan4;
  sbusfd_pkg::chan_t  chan5;
  sbusfd_pkg::chan_t  chan6;
  sbusfd_pkg::chan_t  chan7;
  sbusfd_pkg::chan_t  chan8;
  sbusfd_pkg::chan_t  chan9;
  logic [1:0]         link_status;
  logic               frame_event;

  modport source (
    output valid, output chan0, output chan1, output chan2, output chan3, output chan4,
    output chan5, output chan6, output chan7, output chan8, output chan9,
    output link_status, output frame_event, input ready
  );
  modport sink (
    input valid, input chan0, input chan1, input chan2, input chan3, input chan4,
    input chan5, input chan6, input chan7, input chan8, input chan9,
    input link_status, input frame_event, output ready
  );
endinterface

`default_nettype wire

/* design/sbusfd_chan_scale.sv */
// Scales one raw 11-bit SBUS channel to (raw - 1024) * 100 / 671, toward zero.
// Depends on sbusfd_pkg for the scale constants and channel type.
`default_nettype none

module sbusfd_chan_scale (
  input  wire logic [sbusfd_pkg::RAW_W-1:0] raw,
  output sbusfd_pkg::chan_t                 chan
);
  import sbusfd_pkg::*;

  logic              neg;
  logic [RAW_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [8:0]        quo;

  // Split the offset value into sign and magnitude (magnitude up to 1024)
  assign neg  = ~raw[RAW_W-1];
  assign mag  = raw[RAW_W-1] ? {1'b0, raw[RAW_W-2:0]}
                             : RAW_W'(12'd1024 - {1'b0, raw});

  // Divide by 671 via reciprocal multiply, then restore the sign
  assign prod = PROD_W'(mag) * PROD_W'(SCALE_MULT);
  assign quo  = prod[SCALE_SHIFT +: 9];
  assign chan = neg ? chan_t'(~quo + 9'd1) : chan_t'(quo);

endmodule

`default_nettype wire

/* design/sbus_frame_decoder.sv */
// SBUS frame decoder top level: input register, parser, link timeout, result register.
// Depends on sbusfd_pkg, sbusfd_in_if / sbusfd_out_if and sbusfd_chan_scale.
//
// Usage:
//   in_bus carries requests: opcode 0 with a received serial byte in rx_byte,
//   opcode 1 for a one-millisecond tick. out_bus carries at most one result per
//   request: the ten scaled channels, link_status and frame_event (1 = good
//   frame, 0 = link timeout). The timeout register is written through
//   cfg_wr_en / cfg_wr_data; the user must write it only while the block is idle,
//   which the block itself does not enforce. A request is processed from the input
//   register once the result slot is free; its result is registered and valid on out_bus.
//   Throughput: one request per cycle unless stalled; the input register and
//   the result register are separate, so a request is taken while a result waits.
//   Stall: while a result is not taken, processing halts, the result and the
//   channel state hold, and in_bus.ready drops once the input register fills.
//   Reset: parser waits for a header, channels are zero, status is no device,
//   the millisecond count is zero and the timeout is 500.
`default_nettype none

module sbus_frame_decoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbusfd_in_if.sink  in_bus,
  sbusfd_out_if.source out_bus,
  input  wire logic  cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  import sbusfd_pkg::*;

  // Input register
  logic       in_valid_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;

  // Parser and link state
  parse_phase_t       phase_r, phase_nxt;
  logic [POS_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic [7:0]         store_r [STORE_DEPTH];
  chan_t              chan_r [NUM_CH];
  chan_t              chan_scaled [NUM_CH];
  link_status_t       status_r, status_nxt;
  logic [15:0]        ms_r, ms_nxt, ms_inc;
  logic [15:0]        timeout_r;

  // Result register
  logic out_valid_r;
  logic out_event_r;

  logic proc_fire, proc_byte, proc_tick;
  logic hdr_seen, good_frame, store_we, timeout_fire, emit;
  logic [NUM_CH*CH_BITS-1:0] body_bits;

  // Process the held request when the result slot is free or being emptied
  assign proc_fire    = in_valid_r & (~out_valid_r | out_bus.ready);
  assign proc_byte    = proc_fire & (in_op_r == OP_BYTE);
  assign proc_tick    = proc_fire & (in_op_r == OP_TICK);
  assign in_bus.ready = ~in_valid_r | proc_fire;

  // Hold the request until it is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_op_r   <= in_bus.opcode;
      in_byte_r <= in_bus.rx_byte;
    end
  end

  // Parser next state
  always_comb begin
    phase_nxt = phase_r;
    if (proc_byte) begin
      unique case (phase_r)
        PH_WAIT: phase_nxt = (in_byte_r == HDR_BYTE) ? PH_BODY : PH_WAIT;
        PH_BODY: begin
          if (byte_pos_r >= POS_W'(BODY_LAST)) phase_nxt = PH_FOOT;
        end
        PH_FOOT: phase_nxt = PH_WAIT;
        default: phase_nxt = (in_byte_r == HDR_BYTE) ? PH_BODY : PH_WAIT;
      endcase
    end
  end

  // Parser actions
  always_comb begin
    hdr_seen     = 1'b0;
    good_frame   = 1'b0;
    store_we     = 1'b0;
    byte_pos_nxt = byte_pos_r;
    if (proc_byte) begin
      unique case (phase_r)
        PH_BODY: begin
          store_we     = (byte_pos_r < POS_W'(STORE_DEPTH));
          byte_pos_nxt = byte_pos_r + 1'b1;
        end
        PH_FOOT: begin
          good_frame   = (in_byte_r == FTR_BYTE);
          byte_pos_nxt = '0;
        end
        default: begin
          hdr_seen = (in_byte_r == HDR_BYTE);
          if (hdr_seen) byte_pos_nxt = POS_W'(1);
        end
      endcase
    end
  end

  // Millisecond count and timeout
  assign ms_inc       = (ms_r == MS_MAX) ? ms_r : ms_r + 16'd1;
  assign timeout_fire = proc_tick & (ms_inc > timeout_r) & (status_r != ST_NODEV);
  assign emit         = good_frame | timeout_fire;

  always_comb begin
    ms_nxt     = ms_r;
    status_nxt = status_r;
    if (proc_tick) ms_nxt = ms_inc;
    if (good_frame) begin
      ms_nxt     = '0;
      status_nxt = store_r[BODY_LAST][LOST_FLAG_BIT] ? ST_NOSIG : ST_NORMAL;
    end
    if (timeout_fire) status_nxt = ST_NODEV;
  end

  // Unpack the body LSB first and scale each channel; the last channel ends
  // partway into a byte, so take only its low bits
  always_comb begin
    for (int b = 0; b < (NUM_CH * CH_BITS) / 8; b++) begin
      body_bits[b*8 +: 8] = store_r[b + 1];
    end
    body_bits[NUM_CH*CH_BITS-1 -: (NUM_CH * CH_BITS) % 8] =
      store_r[(NUM_CH * CH_BITS) / 8 + 1][(NUM_CH * CH_BITS) % 8 - 1:0];
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_scale
    sbusfd_chan_scale u_scale (
      .raw  (body_bits[g*CH_BITS +: CH_BITS]),
      .chan (chan_scaled[g])
    );
  end

  // Control and link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      byte_pos_r <= '0;
      status_r   <= ST_NODEV;
      ms_r       <= '0;
      for (int i = 0; i < NUM_CH; i++) chan_r[i] <= '0;
    end else begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      status_r   <= status_nxt;
      ms_r       <= ms_nxt;
      if (good_frame) begin
        for (int i = 0; i < NUM_CH; i++) chan_r[i] <= chan_scaled[i];
      end
    end
  end

  // Frame byte store
  always_ff @(posedge clk) begin
    if (store_we) store_r[byte_pos_r] <= in_byte_r;
    if (hdr_seen) store_r[0] <= HDR_BYTE;
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // Result register; payload comes from the link state, which holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_event_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= emit;
      out_event_r <= good_frame;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.frame_event = out_event_r;
  assign out_bus.link_status = status_r;
  assign out_bus.chan0       = chan_r[0];
  assign out_bus.chan1       = chan_r[1];
  assign out_bus.chan2       = chan_r[2];
  assign out_bus.chan3       = chan_r[3];
  assign out_bus.chan4       = chan_r[4];
  assign out_bus.chan5       = chan_r[5];
  assign out_bus.chan6       = chan_r[6];
  assign out_bus.chan7       = chan_r[7];
  assign out_bus.chan8       = chan_r[8];
  assign out_bus.chan9       = chan_r[9];

  // A pending result keeps its link status
  a_stall_holds_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |=> $stable(status_r) && $stable(chan_r[0]))
    else $error("link state changed under a stalled result");

  // Result kind agrees with the reported status
  a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_event_r == (status_r != ST_NODEV)))
    else $error("frame_event disagrees with link_status");

  // While collecting the body the position stays within bytes 1..23
  a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> byte_pos_r >= POS_W'(1) && byte_pos_r <= POS_W'(BODY_LAST))
    else $error("byte position out of range in frame body");

endmodule

`default_nettype wire
